/* hw/rtl/sspq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sspq_pkg;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ID_W = 8;
	localparam int AGI_W = 8;
	localparam int CLS_W = 2;
	localparam int PRIO_W = 12;
	localparam int STAT_W = 2;
	localparam int MUL_W = 4;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	localparam logic [CLS_W-1:0] CLS_NORMAL = 2'd0;
	localparam logic [CLS_W-1:0] CLS_AGILE = 2'd1;
	localparam logic [CLS_W-1:0] CLS_TANK = 2'd2;

	localparam logic [MUL_W-1:0] MUL_NORMAL = 4'd10;
	localparam logic [MUL_W-1:0] MUL_AGILE = 4'd15;
	localparam logic [MUL_W-1:0] MUL_TANK = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL_DROP = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY_DEQ = 2'd2;

	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_REMOVE
	} act_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic commit;
		act_t act;
		logic [STAT_W-1:0] code;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_deq;
		logic full;
		logic empty;
	} stat_t;

	// priority in tenths: x1.0, x1.5 or x0.8; unused class code counts as normal
	function automatic logic [PRIO_W-1:0] prio_of(input logic [AGI_W-1:0] agility,
		input logic [CLS_W-1:0] kind, input logic alive);
		logic [MUL_W-1:0] mul;
		case (kind)
			CLS_AGILE: mul = MUL_AGILE;
			CLS_TANK: mul = MUL_TANK;
			default: mul = MUL_NORMAL;
		endcase
		if (alive) begin
			prio_of = PRIO_W'(agility) * PRIO_W'(mul);
		end else begin
			prio_of = '0;
		end
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/stable_sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of DEPTH entries (package constant, 16) held in descending
// priority order. Each input beat is an enqueue (opcode 0) or a dequeue of the head
// (opcode 1) and produces exactly one result beat: head id and priority (zero when
// empty), head_valid, occupancy after the operation and a status code (0 ok, 1
// enqueue dropped because full, 2 dequeue on empty ignored). Priority is in tenths:
// agility x10 for normal, x15 for agile, x8 for tank, zero for a dead entry; class
// code 3 counts as normal. A new entry goes behind every entry of equal priority,
// so ties leave in arrival order. Each item is first captured, which registers the
// beat and forms its priority, then executed: the row of compare-and-insert cells
// shifts the whole queue and loads the result register. The block accepts a new
// beat while a result still waits on out_stall; it holds the next result in the
// execute state until the result register is drained.

module stable_sorted_priority_queue_unit import sspq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	// input channel
	input wire logic in_valid,
	output logic in_stall,
	input wire logic opcode,
	input wire logic [ID_W-1:0] entry_id,
	input wire logic [AGI_W-1:0] agility,
	input wire logic [CLS_W-1:0] class_kind,
	input wire logic alive,
	// result channel
	output logic out_valid,
	input wire logic out_stall,
	output logic head_valid,
	output logic [ID_W-1:0] head_id,
	output logic [PRIO_W-1:0] head_priority,
	output logic [CNT_W-1:0] occupancy,
	output logic [STAT_W-1:0] status
);

	cmd_t cmd;
	stat_t stat;

	// sequence the beat: capture, execute, publish
	sspq_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	// hold the sorted row of slots and the result register
	sspq_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.opcode(opcode),
		.entry_id(entry_id),
		.agility(agility),
		.class_kind(class_kind),
		.alive(alive),
		.cmd(cmd),
		.stat(stat),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_priority(head_priority),
		.occupancy(occupancy),
		.status(status)
	);

endmodule

`default_nettype wire

/* hw/rtl/sspq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module sspq_ctrl import sspq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire stat_t stat,
	output cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic out_valid_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '{load: 1'b0, commit: 1'b0, act: ACT_NONE, code: ST_OK};
		cmd.load = in_valid && (state_q == S_IDLE);
		// commit once the result register is free or being drained
		cmd.commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
		if (stat.is_deq) begin
			if (stat.empty) begin
				cmd.code = ST_EMPTY_DEQ;
			end else begin
				cmd.act = ACT_REMOVE;
			end
		end else begin
			if (stat.full) begin
				cmd.code = ST_FULL_DROP;
			end else begin
				cmd.act = ACT_INSERT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cmd.commit) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/sspq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module sspq_datapath import sspq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic opcode,
	input wire logic [ID_W-1:0] entry_id,
	input wire logic [AGI_W-1:0] agility,
	input wire logic [CLS_W-1:0] class_kind,
	input wire logic alive,
	input wire cmd_t cmd,
	output stat_t stat,
	output logic head_valid,
	output logic [ID_W-1:0] head_id,
	output logic [PRIO_W-1:0] head_priority,
	output logic [CNT_W-1:0] occupancy,
	output logic [STAT_W-1:0] status
);

	logic op_q;
	logic [ID_W-1:0] new_id_q;
	logic [PRIO_W-1:0] new_prio_q;

	logic [PRIO_W-1:0] prio_q [DEPTH];
	logic [ID_W-1:0] id_q [DEPTH];
	logic [CNT_W-1:0] count_q;

	logic [PRIO_W-1:0] prio_nxt [DEPTH];
	logic [ID_W-1:0] id_nxt [DEPTH];
	logic [CNT_W-1:0] count_nxt;
	logic [DEPTH-1:0] ge;

	assign stat.is_deq = (op_q == OP_DEQ);
	assign stat.full = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	// one compare-and-insert cell per slot; held entries stay sorted, so ge is a prefix
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		assign ge[g] = (CNT_W'(g) < count_q) && (prio_q[g] >= new_prio_q);

		always_comb begin
			prio_nxt[g] = prio_q[g];
			id_nxt[g] = id_q[g];
			case (cmd.act)
				ACT_INSERT: begin
					if (!ge[g]) begin
						if (g == 0) begin
							prio_nxt[g] = new_prio_q;
							id_nxt[g] = new_id_q;
						end else if (ge[(g > 0) ? g - 1 : 0]) begin
							prio_nxt[g] = new_prio_q;
							id_nxt[g] = new_id_q;
						end else begin
							prio_nxt[g] = prio_q[(g > 0) ? g - 1 : 0];
							id_nxt[g] = id_q[(g > 0) ? g - 1 : 0];
						end
					end
				end
				ACT_REMOVE: begin
					if (g < DEPTH - 1) begin
						prio_nxt[g] = prio_q[(g < DEPTH - 1) ? g + 1 : g];
						id_nxt[g] = id_q[(g < DEPTH - 1) ? g + 1 : g];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cmd.act)
			ACT_INSERT: count_nxt = count_q + CNT_W'(1);
			ACT_REMOVE: count_nxt = count_q - CNT_W'(1);
			default: count_nxt = count_q;
		endcase
	end

	// capture the beat; priority is formed and registered here, apart from the insert
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= opcode;
			new_id_q <= entry_id;
			new_prio_q <= prio_of(agility, class_kind, alive);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				prio_q[i] <= prio_nxt[i];
				id_q[i] <= id_nxt[i];
			end
			head_valid <= (count_nxt != '0);
			head_id <= (count_nxt != '0) ? id_nxt[0] : '0;
			head_priority <= (count_nxt != '0) ? prio_nxt[0] : '0;
			occupancy <= count_nxt;
			status <= cmd.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

endmodule

`default_nettype wire

/* verif/sspq_queue_checker.sv */
`timescale 1ns / 1ps

module sspq_queue_checker import sspq_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic opcode,
	input wire logic [ID_W-1:0] entry_id,
	input wire logic [AGI_W-1:0] agility,
	input wire logic [CLS_W-1:0] class_kind,
	input wire logic alive,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic head_valid,
	input wire logic [ID_W-1:0] head_id,
	input wire logic [PRIO_W-1:0] head_priority,
	input wire logic [CNT_W-1:0] occupancy,
	input wire logic [STAT_W-1:0] status,
	output int fail_count,
	output int heads_due
);

	typedef struct packed {
		logic head_valid;
		logic [ID_W-1:0] head_id;
		logic [PRIO_W-1:0] head_priority;
		logic [CNT_W-1:0] occupancy;
		logic [STAT_W-1:0] status;
	} head_report_t;

	// shadow copy of the queue, front at index 0
	logic [PRIO_W-1:0] rank_row [DEPTH];
	logic [ID_W-1:0] id_row [DEPTH];
	int fill = 0;

	head_report_t due_heads [$];
	head_report_t want;

	int fail_total = 0;
	int due_total = 0;

	assign fail_count = fail_total;
	assign heads_due = due_total;

	function automatic logic [PRIO_W-1:0] rank_tenths(input logic [AGI_W-1:0] agi,
		input logic [CLS_W-1:0] cls, input logic alv);
		logic [PRIO_W-1:0] scale;
		if (cls == CLS_AGILE) begin
			scale = PRIO_W'(15);
		end else if (cls == CLS_TANK) begin
			scale = PRIO_W'(8);
		end else begin
			scale = PRIO_W'(10);
		end
		return alv ? PRIO_W'(agi) * scale : '0;
	endfunction

	// apply one operation to the shadow queue and return the head report it causes
	function automatic head_report_t advance_queue(input logic op, input logic [ID_W-1:0] id,
		input logic [AGI_W-1:0] agi, input logic [CLS_W-1:0] cls, input logic alv);
		head_report_t rep;
		logic [PRIO_W-1:0] r;
		int pos;
		rep.status = ST_OK;
		if (op == OP_ENQ) begin
			if (fill >= DEPTH) begin
				rep.status = ST_FULL_DROP;
			end else begin
				r = rank_tenths(agi, cls, alv);
				pos = 0;
				// equal ranks stay ahead of the newcomer
				while (pos < fill && rank_row[pos] >= r) pos++;
				for (int k = fill; k > pos; k--) begin
					rank_row[k] = rank_row[k-1];
					id_row[k] = id_row[k-1];
				end
				rank_row[pos] = r;
				id_row[pos] = id;
				fill++;
			end
		end else begin
			if (fill == 0) begin
				rep.status = ST_EMPTY_DEQ;
			end else begin
				for (int k = 1; k < fill; k++) begin
					rank_row[k-1] = rank_row[k];
					id_row[k-1] = id_row[k];
				end
				fill--;
			end
		end
		rep.head_valid = (fill > 0);
		rep.head_id = (fill > 0) ? id_row[0] : '0;
		rep.head_priority = (fill > 0) ? rank_row[0] : '0;
		rep.occupancy = CNT_W'(fill);
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fail_total++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_heads.size() == 0) begin
					$display("%0t: result beat with nothing expected, expected none, actual id %0d",
						$time, head_id);
					fail_total++;
				end else begin
					want = due_heads.pop_front();
					check_field("head_valid", 16'(want.head_valid), 16'(head_valid));
					check_field("head_id", 16'(want.head_id), 16'(head_id));
					check_field("head_priority", 16'(want.head_priority),
						16'(head_priority));
					check_field("occupancy", 16'(want.occupancy), 16'(occupancy));
					check_field("status", 16'(want.status), 16'(status));
				end
			end
			if (in_valid && !in_stall) begin
				due_heads.push_back(advance_queue(opcode, entry_id, agility, class_kind, alive));
			end
			due_total = due_heads.size();
		end
	end

endmodule

/* verif/stable_sorted_priority_queue_unit_test.sv */
`timescale 1ns / 1ps

module stable_sorted_priority_queue_unit_test;
	import sspq_pkg::*;

	// class code 3 has no meaning of its own; the block treats it as normal
	localparam logic [CLS_W-1:0] CLS_SPARE = 2'd3;
	localparam int RANDOM_BEATS = 1550;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic opcode;
	logic [ID_W-1:0] entry_id;
	logic [AGI_W-1:0] agility;
	logic [CLS_W-1:0] class_kind;
	logic alive;
	logic out_valid;
	logic out_stall;
	logic head_valid;
	logic [ID_W-1:0] head_id;
	logic [PRIO_W-1:0] head_priority;
	logic [CNT_W-1:0] occupancy;
	logic [STAT_W-1:0] status;

	int fail_count;
	int heads_due;

	// random idling on both channels; cleared for the calm stretch
	logic idle_on;

	stable_sorted_priority_queue_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.entry_id(entry_id),
		.agility(agility),
		.class_kind(class_kind),
		.alive(alive),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_priority(head_priority),
		.occupancy(occupancy),
		.status(status)
	);

	sspq_queue_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.entry_id(entry_id),
		.agility(agility),
		.class_kind(class_kind),
		.alive(alive),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.head_valid(head_valid),
		.head_id(head_id),
		.head_priority(head_priority),
		.occupancy(occupancy),
		.status(status),
		.fail_count(fail_count),
		.heads_due(heads_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Result side: stall at random on each falling edge, never while idling is off.
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_stall <= idle_on && ($urandom_range(0, 99) < 17);
		end
	end

	// Offer one beat and hold it until accepted. An optional gap comes first; the
	// gap lowers valid on one falling edge only, so valid is never lowered and
	// raised in the same step.
	task automatic send_beat(input logic op, input logic [ID_W-1:0] id,
		input logic [AGI_W-1:0] agi, input logic [CLS_W-1:0] cls, input logic alv);
		if (idle_on && $urandom_range(0, 99) < 17) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		opcode <= op;
		entry_id <= id;
		agility <= agi;
		class_kind <= cls;
		alive <= alv;
		in_valid <= 1'b1;
		// hold the payload until a rising edge sees stall low
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted head report has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (heads_due != 0) @(negedge clk);
	endtask

	// One random beat. enq_pct steers the fill level, so that phases run the
	// queue toward full (drops) or toward empty (ignored dequeues). Agility is
	// often drawn from a short list to make equal ranks, across classes too
	// (tank 125 and normal 100 both give 1000).
	task automatic random_beat(input int enq_pct);
		logic [AGI_W-1:0] agi;
		logic op;
		op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
		case ($urandom_range(0, 3))
			0: agi = 8'd100;
			1: agi = 8'd125;
			2: agi = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'd0;
			default: agi = AGI_W'($urandom_range(0, 255));
		endcase
		if ($urandom_range(0, 1) == 0) agi = AGI_W'($urandom_range(0, 255));
		send_beat(op, ID_W'($urandom_range(0, 255)), agi, CLS_W'($urandom_range(0, 3)),
			$urandom_range(0, 99) < 85);
	endtask

	initial begin
		in_valid = 1'b0;
		opcode = OP_ENQ;
		entry_id = '0;
		agility = '0;
		class_kind = CLS_NORMAL;
		alive = 1'b0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Dequeue on an empty queue, once with all-ones don't-care fields.
		send_beat(OP_DEQ, 8'h00, 8'h00, CLS_NORMAL, 1'b0);
		send_beat(OP_DEQ, 8'hFF, 8'hFF, CLS_SPARE, 1'b1);

		// Fill all sixteen slots: field extremes, each class, dead entries and ties.
		send_beat(OP_ENQ, 8'h00, 8'd0, CLS_NORMAL, 1'b1);
		send_beat(OP_ENQ, 8'hFF, 8'd255, CLS_AGILE, 1'b1);
		send_beat(OP_ENQ, 8'h01, 8'd255, CLS_NORMAL, 1'b1);
		send_beat(OP_ENQ, 8'h02, 8'd255, CLS_TANK, 1'b1);
		send_beat(OP_ENQ, 8'h03, 8'd255, CLS_SPARE, 1'b1);
		send_beat(OP_ENQ, 8'h04, 8'd255, CLS_AGILE, 1'b0);
		send_beat(OP_ENQ, 8'h05, 8'd125, CLS_TANK, 1'b1);
		send_beat(OP_ENQ, 8'h06, 8'd100, CLS_NORMAL, 1'b1);
		send_beat(OP_ENQ, 8'h07, 8'd1, CLS_AGILE, 1'b1);
		send_beat(OP_ENQ, 8'h08, 8'd128, CLS_NORMAL, 1'b1);
		send_beat(OP_ENQ, 8'h09, 8'd170, CLS_AGILE, 1'b1);
		send_beat(OP_ENQ, 8'hAA, 8'h55, CLS_TANK, 1'b1);
		send_beat(OP_ENQ, 8'h55, 8'hAA, CLS_SPARE, 1'b0);
		send_beat(OP_ENQ, 8'h0A, 8'd2, CLS_TANK, 1'b1);
		send_beat(OP_ENQ, 8'h0B, 8'd1, CLS_NORMAL, 1'b1);
		send_beat(OP_ENQ, 8'h0C, 8'd3, CLS_AGILE, 1'b1);

		// Queue is full: this one is dropped. Then pop the head with junk fields.
		send_beat(OP_ENQ, 8'hEE, 8'd200, CLS_AGILE, 1'b1);
		send_beat(OP_DEQ, 8'hFF, 8'hFF, CLS_SPARE, 1'b1);

		// Random part in phases of 100 beats: mostly enqueue, balanced, mostly dequeue.
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			// calm stretch: no gaps and no stalls at all
			if (i == 600) idle_on = 1'b0;
			if (i == 900) idle_on = 1'b1;
			// let the pipeline run dry twice before carrying on
			if (i == 300 || i == 1200) drain_results();
			case ((i / 100) % 3)
				0: random_beat(80);
				1: random_beat(50);
				default: random_beat(20);
			endcase
		end

		// Wind down: drop valid, collect every report, then watch for strays.
		drain_results();
		repeat (20) @(negedge clk);

		if (fail_count == 0 && heads_due == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sspq_pkg.sv
hw/rtl/sspq_ctrl.sv
hw/rtl/sspq_datapath.sv
hw/rtl/stable_sorted_priority_queue_unit.sv
verif/sspq_queue_checker.sv
verif/stable_sorted_priority_queue_unit_test.sv
